// File: hdl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types, character constants and operator token helpers for the
// infix to postfix converter.
// ----------------------------------------------------------------------------
package ifp_pkg;

    // Operator stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int TOK_W       = 3;

    // Stack tokens.
    typedef logic [TOK_W-1:0] tok_t;
    localparam tok_t TOK_OPEN = 3'd0;
    localparam tok_t TOK_ADD  = 3'd1;
    localparam tok_t TOK_SUB  = 3'd2;
    localparam tok_t TOK_MUL  = 3'd3;
    localparam tok_t TOK_DIV  = 3'd4;

    // ASCII characters of interest.
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // Error codes carried on result beats.
    typedef logic [1:0] err_t;
    localparam err_t ERR_OK       = 2'd0;
    localparam err_t ERR_OVERFLOW = 2'd1;
    localparam err_t ERR_CLOSE    = 2'd2;
    localparam err_t ERR_OPEN     = 2'd3;

    // Input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_expr;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       expr_done;
        err_t       error_code;
    } out_beat_t;

    // Character emitted for a stacked operator token.
    function automatic logic [7:0] tok_char(input tok_t t);
        logic [7:0] c;
        case (t)
            TOK_ADD: c = CH_ADD;
            TOK_SUB: c = CH_SUB;
            TOK_MUL: c = CH_MUL;
            TOK_DIV: c = CH_DIV;
            default: c = CH_OPEN;
        endcase
        return c;
    endfunction

    // Precedence: multiply and divide bind tighter than add and subtract.
    function automatic logic [1:0] prec_of(input tok_t t);
        logic [1:0] p;
        case (t)
            TOK_MUL, TOK_DIV: p = 2'd2;
            TOK_ADD, TOK_SUB: p = 2'd1;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

    // Token for an operator character.
    function automatic tok_t tok_of_char(input logic [7:0] c);
        tok_t t;
        case (c)
            CH_ADD:  t = TOK_ADD;
            CH_SUB:  t = TOK_SUB;
            CH_MUL:  t = TOK_MUL;
            CH_DIV:  t = TOK_DIV;
            default: t = TOK_OPEN;
        endcase
        return t;
    endfunction

endpackage

// File: hdl/ifp_ram.sv
// ----------------------------------------------------------------------------
// ifp_ram
// Generic single-clock RAM with one write port and one registered read port.
// Read data holds its value when no read is issued.
// ----------------------------------------------------------------------------
module ifp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ifp_out_stage.sv
// ----------------------------------------------------------------------------
// ifp_out_stage
// Output register for result beats. It separates the converter core from
// back pressure on the result channel.
// ----------------------------------------------------------------------------
module ifp_out_stage
    import ifp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_beat_t beat,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_beat_t data_reg;

    // The register can take a new beat when empty or when its beat leaves.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// A digit or '.' passes through the pending register and then the output register,
// and the next beat is taken once the controller is back in idle; a push needing no pop leaves it idle.
// Errors found in idle and an end on an empty stack go straight to flush. Other items read the stack top,
// examine one entry per stack read (popped, dropped or stopping the run) and reach flush via the tail
// state unless a matching '(' ends it; at most one stack read per cycle, and they wait on output stalls.
// Reset clears the controller and stack count; the stack memory is not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import ifp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POP   = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    // What started the current pop run.
    typedef enum logic [1:0] {
        MODE_OP    = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tok_t             op_tok_reg, op_tok_next;
    logic             open_left_reg, open_left_next;
    logic             pend_valid_reg, pend_valid_next;
    out_beat_t        pend_reg, pend_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    tok_t              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    tok_t              ram_rdata;

    logic      out_load;
    out_beat_t out_beat;
    logic      out_free;

    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_m2;
    logic             stack_full;
    logic             stack_empty;
    logic             top_is_open;
    logic             last_entry;
    logic             emit_ok;
    logic [7:0]       c;

    // Operator stack memory.
    ifp_ram #(
        .WIDTH (TOK_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result output register.
    ifp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .beat      (out_beat),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign cnt_dec     = count_reg - CNT_W'(1);
    assign cnt_m2      = count_reg - CNT_W'(2);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign last_entry  = (count_reg == CNT_W'(1));
    assign top_is_open = (ram_rdata == TOK_OPEN) || (ram_rdata > TOK_DIV);
    assign c           = in_data.char_in;

    // A new beat may enter the pending register when it is empty or when
    // the pending beat can move on to the output register.
    assign emit_ok  = !pend_valid_reg || out_free;
    assign in_ready = (state_reg == ST_IDLE);

    // Controller: reads the stack top, pops, pushes, emits one beat a cycle unless output stalls.
    // The newest result waits in a pending register until it is known
    // whether it is the last one of its input beat.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        op_tok_next     = op_tok_reg;
        open_left_next  = open_left_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wdata       = op_tok_reg;
        ram_re          = 1'b0;
        ram_raddr       = cnt_dec[ADDR_W-1:0];
        out_load        = 1'b0;
        out_beat        = pend_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.end_of_expr)
                    begin
                        mode_next      = MODE_END;
                        open_left_next = 1'b0;
                        if (stack_empty)
                        begin
                            pend_valid_next = 1'b1;
                            pend_next       = '{CH_NONE, 1'b1, 1'b1, ERR_OK};
                            state_next      = ST_FLUSH;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        case (c) inside
                            [CH_ZERO:CH_NINE], CH_DOT:
                            begin
                                pend_valid_next = 1'b1;
                                pend_next       = '{c, 1'b1, 1'b0, ERR_OK};
                                state_next      = ST_FLUSH;
                            end
                            CH_OPEN:
                            begin
                                if (stack_full)
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_next  = '{CH_NONE, 1'b1, 1'b0, ERR_OVERFLOW};
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = TOK_OPEN;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            CH_CLOSE:
                            begin
                                mode_next = MODE_CLOSE;
                                if (stack_empty)
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_next  = '{CH_NONE, 1'b1, 1'b0, ERR_CLOSE};
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = ST_POP;
                                end
                            end
                            CH_ADD, CH_SUB, CH_MUL, CH_DIV:
                            begin
                                mode_next   = MODE_OP;
                                op_tok_next = tok_of_char(c);
                                if (stack_empty)
                                begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = tok_of_char(c);
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = ST_POP;
                                end
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_POP:
            begin
                // Entries that are dropped without a result.
                if (top_is_open && mode_reg != MODE_OP)
                begin
                    count_next = cnt_dec;
                    if (mode_reg == MODE_CLOSE)
                    begin
                        // Matching open found: any pending beat closes the run.
                        pend_next.run_last = 1'b1;
                        state_next         = ST_FLUSH;
                    end
                    else
                    begin
                        open_left_next = 1'b1;
                        if (last_entry)
                        begin
                            state_next = ST_TAIL;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m2[ADDR_W-1:0];
                        end
                    end
                end
                else if (mode_reg == MODE_OP &&
                         (top_is_open || prec_of(ram_rdata) < prec_of(op_tok_reg)))
                begin
                    // Stop popping; the operator is pushed next if the stack has room.
                    state_next = ST_TAIL;
                end
                else if (emit_ok)
                begin
                    // Pop an operator and emit it.
                    out_load        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_next       = '{tok_char(ram_rdata), 1'b0, 1'b0, ERR_OK};
                    count_next      = cnt_dec;
                    if (last_entry)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_m2[ADDR_W-1:0];
                    end
                end
            end

            ST_TAIL:
            begin
                if (mode_reg == MODE_OP && !stack_full)
                begin
                    // Push the operator; no further result.
                    ram_we             = 1'b1;
                    ram_wdata          = op_tok_reg;
                    count_next         = count_reg + CNT_W'(1);
                    pend_next.run_last = 1'b1;
                    state_next         = ST_FLUSH;
                end
                else if (emit_ok)
                begin
                    // One closing beat: end marker or error.
                    out_load        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    case (mode_reg)
                        MODE_END:
                        begin
                            pend_next = '{CH_NONE, 1'b1, 1'b1,
                                          open_left_reg ? ERR_OPEN : ERR_OK};
                        end
                        MODE_CLOSE:
                        begin
                            pend_next = '{CH_NONE, 1'b1, 1'b0, ERR_CLOSE};
                        end
                        default:
                        begin
                            pend_next = '{CH_NONE, 1'b1, 1'b0, ERR_OVERFLOW};
                        end
                    endcase
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_OP;
            count_reg      <= '0;
            open_left_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            open_left_reg  <= open_left_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_tok_reg <= op_tok_next;
        pend_reg   <= pend_next;
    end

endmodule

// File: dv/ifp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ifp_checker
// Watches both channels of the infix to postfix converter. Every input beat
// taken is run through a shunting-yard model of the operator stack, and the
// postfix beats it should produce are queued. Every result beat taken is
// compared field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module ifp_checker
    import ifp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_beat_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_beat_t out_data,
    output int        fail_count,
    output int        pending_results
);

    localparam int REPORT_LIMIT = 10;

    // Model of the operator stack and the postfix beats still owed.
    tok_t      pending_ops [STACK_DEPTH];
    int        pending_depth;
    out_beat_t postfix_q [$];
    int        fail_tally;
    int        reported;

    // Binding strength of a stacked token; an open parenthesis never pops.
    function automatic int op_rank(input tok_t tok);
        int rank;
        case (tok)
            TOK_MUL, TOK_DIV: rank = 2;
            TOK_ADD, TOK_SUB: rank = 1;
            default:          rank = 0;
        endcase
        return rank;
    endfunction

    // ASCII code written out when an operator leaves the stack.
    function automatic logic [7:0] op_ascii(input tok_t tok);
        logic [7:0] c;
        case (tok)
            TOK_ADD: c = CH_ADD;
            TOK_SUB: c = CH_SUB;
            TOK_MUL: c = CH_MUL;
            default: c = CH_DIV;
        endcase
        return c;
    endfunction

    function automatic out_beat_t make_beat(input logic [7:0] c, input logic done,
                                            input err_t err);
        out_beat_t beat;
        beat.char_out   = c;
        beat.run_last   = 1'b0;
        beat.expr_done  = done;
        beat.error_code = err;
        return beat;
    endfunction

    // Pushes a token; returns 0 when the stack is full and the token is dropped.
    function automatic bit stack_push(input tok_t tok);
        if (pending_depth >= STACK_DEPTH)
            return 1'b0;
        pending_ops[pending_depth] = tok;
        pending_depth++;
        return 1'b1;
    endfunction

    // Works out the postfix beats caused by one input beat and queues them.
    task automatic predict_postfix(input in_beat_t beat);
        out_beat_t run [$];
        tok_t      tok;
        logic [7:0] c;
        bit        open_left;
        bit        matched;
        bit        is_op;
        c = beat.char_in;
        is_op = 1'b0;
        tok = TOK_OPEN;
        case (c)
            CH_ADD: begin tok = TOK_ADD; is_op = 1'b1; end
            CH_SUB: begin tok = TOK_SUB; is_op = 1'b1; end
            CH_MUL: begin tok = TOK_MUL; is_op = 1'b1; end
            CH_DIV: begin tok = TOK_DIV; is_op = 1'b1; end
            default: ;
        endcase

        if (beat.end_of_expr) begin
            // Flush: operators come out, open parentheses are dropped.
            open_left = 1'b0;
            while (pending_depth > 0) begin
                pending_depth--;
                if (pending_ops[pending_depth] == TOK_OPEN)
                    open_left = 1'b1;
                else
                    run.push_back(make_beat(op_ascii(pending_ops[pending_depth]),
                                            1'b0, ERR_OK));
            end
            run.push_back(make_beat(CH_NONE, 1'b1, open_left ? ERR_OPEN : ERR_OK));
        end
        else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
            run.push_back(make_beat(c, 1'b0, ERR_OK));
        end
        else if (c == CH_OPEN) begin
            if (!stack_push(TOK_OPEN))
                run.push_back(make_beat(CH_NONE, 1'b0, ERR_OVERFLOW));
        end
        else if (c == CH_CLOSE) begin
            // Pop down to the matching open parenthesis, which is discarded.
            matched = 1'b0;
            while (pending_depth > 0 && !matched) begin
                pending_depth--;
                if (pending_ops[pending_depth] == TOK_OPEN)
                    matched = 1'b1;
                else
                    run.push_back(make_beat(op_ascii(pending_ops[pending_depth]),
                                            1'b0, ERR_OK));
            end
            if (!matched)
                run.push_back(make_beat(CH_NONE, 1'b0, ERR_CLOSE));
        end
        else if (is_op) begin
            // Pop everything that binds at least as tightly, then push.
            while (pending_depth > 0 && pending_ops[pending_depth-1] != TOK_OPEN &&
                   op_rank(pending_ops[pending_depth-1]) >= op_rank(tok)) begin
                pending_depth--;
                run.push_back(make_beat(op_ascii(pending_ops[pending_depth]),
                                        1'b0, ERR_OK));
            end
            if (!stack_push(tok))
                run.push_back(make_beat(CH_NONE, 1'b0, ERR_OVERFLOW));
        end

        if (run.size() > 0)
            run[run.size()-1].run_last = 1'b1;
        foreach (run[i])
            postfix_q.push_back(run[i]);
    endtask

    // Sample both channels at the clock edge, predict, then compare.
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            pending_depth = 0;
            postfix_q.delete();
            fail_tally = 0;
            reported = 0;
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_postfix(in_data);

            if (out_valid && out_ready)
            begin
                if (postfix_q.size() == 0)
                begin
                    fail_tally++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("%0t: unexpected result beat char=%02h last=%0b done=%0b err=%0d",
                                 $realtime, out_data.char_out, out_data.run_last,
                                 out_data.expr_done, out_data.error_code);
                    end
                end
                else
                begin
                    want = postfix_q.pop_front();
                    if (out_data.char_out !== want.char_out ||
                        out_data.run_last !== want.run_last ||
                        out_data.expr_done !== want.expr_done ||
                        out_data.error_code !== want.error_code)
                    begin
                        fail_tally++;
                        if (reported < REPORT_LIMIT)
                        begin
                            reported++;
                            $display("%0t: result mismatch char exp=%02h act=%02h last exp=%0b act=%0b",
                                     $realtime, want.char_out, out_data.char_out,
                                     want.run_last, out_data.run_last);
                            $display("    done exp=%0b act=%0b err exp=%0d act=%0d",
                                     want.expr_done, out_data.expr_done,
                                     want.error_code, out_data.error_code);
                        end
                    end
                end
            end

            fail_count <= fail_tally;
            pending_results <= postfix_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives character streams into the infix to postfix converter: a directed
// walk through digits, operators, parentheses and the error cases, a stack
// fill past its depth, then random expressions, broken sequences and deep
// nesting under four patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top
    import ifp_pkg::*;
();

    localparam int ITEM_TARGET = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 50;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;
    logic hold_request = 1'b0;

    infix_to_postfix_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ifp_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one beat, with a random gap first, and waits until it is taken.
    task automatic send_char(input logic [7:0] c, input logic eoe);
        in_beat_t beat;
        beat.char_in = c;
        beat.end_of_expr = eoe;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        if (eoe || (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_OPEN ||
            c == CH_CLOSE || c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV)
            items_sent++;
    endtask

    // Sender pauses until every queued result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [7:0] random_numeral();
        if ($urandom_range(7) == 0)
            return CH_DOT;
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_operator();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = CH_ADD;
            1:       c = CH_SUB;
            2:       c = CH_MUL;
            default: c = CH_DIV;
        endcase
        return c;
    endfunction

    // A balanced expression with random operands, operators and nesting.
    task automatic send_formula();
        int nest;
        int terms;
        nest = 0;
        terms = $urandom_range(1, 8);
        for (int t = 0; t < terms; t++)
        begin
            while (nest < 6 && $urandom_range(3) == 0)
            begin
                send_char(CH_OPEN, 1'b0);
                nest++;
            end
            repeat ($urandom_range(1, 3)) send_char(random_numeral(), 1'b0);
            while (nest > 0 && $urandom_range(2) == 0)
            begin
                send_char(CH_CLOSE, 1'b0);
                nest--;
            end
            // Occasional stray character inside the expression.
            if ($urandom_range(9) == 0)
                send_char(8'($urandom_range(255)), 1'b0);
            if (t != terms - 1)
                send_char(random_operator(), 1'b0);
        end
        repeat (nest) send_char(CH_CLOSE, 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // A sequence of random tokens and raw bytes, usually unbalanced.
    task automatic send_garbled();
        logic [7:0] c;
        repeat ($urandom_range(3, 16))
        begin
            case ($urandom_range(4))
                0:       c = CH_OPEN;
                1:       c = CH_CLOSE;
                2:       c = random_operator();
                3:       c = random_numeral();
                default: c = 8'($urandom_range(255));
            endcase
            send_char(c, 1'b0);
        end
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // Deep nesting that often runs into the stack limit.
    task automatic send_deep_nest();
        repeat ($urandom_range(8, 20))
        begin
            if ($urandom_range(2) == 0)
            begin
                send_char(random_numeral(), 1'b0);
                send_char(random_operator(), 1'b0);
            end
            else
                send_char(CH_OPEN, 1'b0);
        end
        send_char(random_numeral(), 1'b0);
        repeat ($urandom_range(0, 8)) send_char(CH_CLOSE, 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: precedence pops, both close errors, ignored bytes,
        // empty pops and a leftover open at the end.
        send_char(CH_ZERO, 1'b0);
        send_char(CH_ADD, 1'b0);
        send_char(CH_NINE, 1'b0);
        send_char(CH_MUL, 1'b0);
        send_char(CH_DOT, 1'b0);
        send_char(CH_DIV, 1'b0);
        send_char(CH_SUB, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_NONE, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_SUB, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(CH_OPEN, 1'b0);
        send_char(8'h37, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(8'hFF, 1'b1);
        drain();

        // Fill the stack, then overflow it with an operator and a parenthesis.
        repeat (STACK_DEPTH) send_char(CH_OPEN, 1'b0);
        send_char(CH_MUL, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(8'h55, 1'b1);
        drain();

        // Random phases with different idling, each ending in a full drain.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (phase == 0)
                hold_request <= 1'b1;
            while (items_sent < (ITEM_TARGET * (phase + 1)) / 4)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_formula();
                else if (pick < 85)
                    send_garbled();
                else
                    send_deep_nest();
            end
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hdl/ifp_pkg.sv
hdl/ifp_ram.sv
hdl/ifp_out_stage.sv
hdl/infix_to_postfix_converter.sv
dv/ifp_checker.sv
dv/tb_top.sv
